// ===== design/soc_memory_map_byte_access_top_macros.svh =====
// ----------------------------------------------------------------------------
// soc_memory_map_byte_access_top_macros.svh
// Assertion macros shared by the memory map modules.
// ----------------------------------------------------------------------------
`ifndef SOC_MEMORY_MAP_BYTE_ACCESS_TOP_MACROS_SVH
`define SOC_MEMORY_MAP_BYTE_ACCESS_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SMBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SMBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/smba_pkg.sv =====
// ----------------------------------------------------------------------------
// smba_pkg
// Types, codes and defaults shared by the byte access memory map.
// ----------------------------------------------------------------------------
package smba_pkg;

  localparam int INSTR_BYTES_DEF = 4096;
  localparam int DATA_BYTES_DEF  = 4096;
  localparam int STACK_BYTES_DEF = 1024;
  localparam int VIDEO_BYTES_DEF = 4800;

  localparam logic [31:0] RST_INSTR_BASE  = 32'h0040_0000;
  localparam logic [31:0] RST_DATA_BASE   = 32'h1001_0000;
  localparam logic [31:0] RST_VIDEO_BASE  = 32'h1002_0000;
  localparam logic [31:0] RST_STACK_TOP   = 32'h7FFF_FFFF;
  localparam logic [31:0] RST_KEYPAD_ADDR = 32'hFFFF_0000;
  localparam logic [31:0] RST_TIMER_ADDR  = 32'hFFFF_0004;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_INSTR_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIDEO_BASE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STACK_TOP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEYPAD_ADDR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_ADDR  = 3'd5;

  localparam logic [2:0] MODE_RD_BYTE = 3'd0;
  localparam logic [2:0] MODE_RD_HALF = 3'd1;
  localparam logic [2:0] MODE_RD_WORD = 3'd2;
  localparam logic [2:0] MODE_WR_BYTE = 3'd3;
  localparam logic [2:0] MODE_WR_HALF = 3'd4;
  localparam logic [2:0] MODE_WR_WORD = 3'd5;

  typedef enum logic [2:0] {
    REGION_NONE,
    REGION_INSTR,
    REGION_DATA,
    REGION_VIDEO,
    REGION_STACK
  } region_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ACCESS,
    ST_MERGE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic decode;
    logic port_load;
    logic access;
    logic merge;
    logic advance;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic port_hit;
    logic mode_bad;
    logic is_write;
    logic last_lane;
    logic out_busy;
  } status_t;

  // Index of the final byte lane for a mode.
  function automatic logic [1:0] last_lane_of(input logic [2:0] m);
    logic [1:0] n;
    case (m)
      MODE_RD_HALF, MODE_WR_HALF: n = 2'd1;
      MODE_RD_WORD, MODE_WR_WORD: n = 2'd3;
      default:                    n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== design/smba_ram.sv =====
// ----------------------------------------------------------------------------
// smba_ram
// Single-port byte memory with registered read data.
// ----------------------------------------------------------------------------
module smba_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

// ===== design/smba_ctrl.sv =====
// ----------------------------------------------------------------------------
// smba_ctrl
// Sequencer: clearing sweep, item capture, per-lane decode/access/merge.
// ----------------------------------------------------------------------------
`include "soc_memory_map_byte_access_top_macros.svh"

module smba_ctrl import smba_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.mode_bad) begin
          state_next = ST_FINISH;
        end else if (status.port_hit) begin
          cmd.port_load = 1'b1;
          state_next    = ST_FINISH;
        end else begin
          cmd.decode = 1'b1;
          state_next = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd.access = 1'b1;
        if (status.is_write) begin
          // writes need no read return: move on to the next lane at once
          cmd.advance = 1'b1;
          state_next  = status.last_lane ? ST_FINISH : ST_DECODE;
        end else begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin
        cmd.merge   = 1'b1;
        cmd.advance = 1'b1;
        state_next  = status.last_lane ? ST_FINISH : ST_DECODE;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!status.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `SMBA_ASSERT_NXT(a_accept_decode, in_valid && in_ready, state == ST_DECODE, "accepted item did not move to decode")
  `SMBA_ASSERT_NXT(a_clear_once, state != ST_CLEAR, state != ST_CLEAR, "clearing sweep restarted")
  `SMBA_ASSERT_NXT(a_port_direct, (state == ST_DECODE) && status.port_hit && !status.mode_bad, state == ST_FINISH, "port read touched memory")

endmodule

// ===== design/smba_dpath.sv =====
// ----------------------------------------------------------------------------
// smba_dpath
// Config registers, item registers, byte decoder, stores and result register.
// ----------------------------------------------------------------------------
`include "soc_memory_map_byte_access_top_macros.svh"

module smba_dpath import smba_pkg::*; #(
  parameter int INSTR_BYTES = INSTR_BYTES_DEF,
  parameter int DATA_BYTES  = DATA_BYTES_DEF,
  parameter int STACK_BYTES = STACK_BYTES_DEF,
  parameter int VIDEO_BYTES = VIDEO_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [2:0]           mode,
  input  logic [31:0]          address,
  input  logic [31:0]          write_data,
  input  logic [15:0]          keypad_state,
  input  logic [31:0]          timer_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          read_data
);

  localparam int MAX_ID    = (INSTR_BYTES > DATA_BYTES) ? INSTR_BYTES : DATA_BYTES;
  localparam int MAX_VS    = (VIDEO_BYTES > STACK_BYTES) ? VIDEO_BYTES : STACK_BYTES;
  localparam int MAX_BYTES = (MAX_ID > MAX_VS) ? MAX_ID : MAX_VS;
  localparam int OW        = $clog2(MAX_BYTES);
  localparam int IAW       = $clog2(INSTR_BYTES);
  localparam int DAW       = $clog2(DATA_BYTES);
  localparam int VAW       = $clog2(VIDEO_BYTES);
  localparam int SAW       = $clog2(STACK_BYTES);

  localparam logic [31:0] RST_STACK_BASE = RST_STACK_TOP - 32'(STACK_BYTES) + 32'd1;

  // configuration
  logic [31:0] instr_base, data_base, video_base, stack_base;
  logic [31:0] keypad_port_addr, timer_port_addr;

  // captured item
  logic [2:0]  mode_r;
  logic [31:0] addr_r, wdata_r, timer_r;
  logic [15:0] keypad_r;

  // lane walk
  logic [31:0]   lane_addr;
  logic [1:0]    lane;
  region_t       region;
  logic [OW-1:0] offset;
  logic [31:0]   result;
  logic [OW-1:0] clr_cnt;

  logic [31:0] off_instr, off_data, off_video, off_stack;
  logic        is_write;
  logic [7:0]  lane_wbyte, rbyte;

  logic           instr_en, instr_we, data_en, data_we;
  logic           video_en, video_we, stack_en, stack_we;
  logic [IAW-1:0] instr_addr;
  logic [DAW-1:0] data_addr;
  logic [VAW-1:0] video_addr;
  logic [SAW-1:0] stack_addr;
  logic [7:0]     mem_wdata;
  logic [7:0]     instr_rdata, data_rdata, video_rdata, stack_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      instr_base       <= RST_INSTR_BASE;
      data_base        <= RST_DATA_BASE;
      video_base       <= RST_VIDEO_BASE;
      stack_base       <= RST_STACK_BASE;
      keypad_port_addr <= RST_KEYPAD_ADDR;
      timer_port_addr  <= RST_TIMER_ADDR;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_INSTR_BASE:  instr_base       <= cfg_data;
        REG_DATA_BASE:   data_base        <= cfg_data;
        REG_VIDEO_BASE:  video_base       <= cfg_data;
        // keep the stack as its first byte address
        REG_STACK_TOP:   stack_base       <= cfg_data - 32'(STACK_BYTES) + 32'd1;
        REG_KEYPAD_ADDR: keypad_port_addr <= cfg_data;
        REG_TIMER_ADDR:  timer_port_addr  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    is_write   = mode_r inside {MODE_WR_BYTE, MODE_WR_HALF, MODE_WR_WORD};
    off_instr  = lane_addr - instr_base;
    off_data   = lane_addr - data_base;
    off_video  = lane_addr - video_base;
    off_stack  = lane_addr - stack_base;
    lane_wbyte = wdata_r[{lane, 3'b000} +: 8];
  end

  always_comb begin
    status            = '0;
    status.clear_done = (clr_cnt == OW'(MAX_BYTES - 1));
    status.port_hit   = (mode_r == MODE_RD_WORD) &&
                        ((addr_r == keypad_port_addr) || (addr_r == timer_port_addr));
    status.mode_bad   = (mode_r > MODE_WR_WORD);
    status.is_write   = is_write;
    status.last_lane  = (lane == last_lane_of(mode_r));
    status.out_busy   = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= mode;
      addr_r   <= address;
      wdata_r  <= write_data;
      keypad_r <= keypad_state;
      timer_r  <= timer_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      lane    <= '0;
      region  <= REGION_NONE;
    end else begin
      if (cmd.clear && !status.clear_done) begin
        clr_cnt <= clr_cnt + OW'(1);
      end
      if (cmd.load) begin
        lane <= '0;
      end else if (cmd.advance) begin
        lane <= lane + 2'd1;
      end
      if (cmd.decode) begin
        // fixed priority: instruction, data, video, stack
        if (off_instr < 32'(INSTR_BYTES)) begin
          region <= REGION_INSTR;
        end else if (off_data < 32'(DATA_BYTES)) begin
          region <= REGION_DATA;
        end else if (off_video < 32'(VIDEO_BYTES)) begin
          region <= REGION_VIDEO;
        end else if (off_stack < 32'(STACK_BYTES)) begin
          region <= REGION_STACK;
        end else begin
          region <= REGION_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lane_addr <= address;
    end else if (cmd.advance) begin
      lane_addr <= lane_addr + 32'd1;
    end
    if (cmd.decode) begin
      if (off_instr < 32'(INSTR_BYTES)) begin
        offset <= off_instr[OW-1:0];
      end else if (off_data < 32'(DATA_BYTES)) begin
        offset <= off_data[OW-1:0];
      end else if (off_video < 32'(VIDEO_BYTES)) begin
        offset <= off_video[OW-1:0];
      end else begin
        offset <= off_stack[OW-1:0];
      end
    end
    if (cmd.load) begin
      result <= '0;
    end else if (cmd.port_load) begin
      result <= (addr_r == keypad_port_addr) ? {16'h0000, keypad_r} : timer_r;
    end else if (cmd.merge) begin
      result[{lane, 3'b000} +: 8] <= rbyte;
    end
  end

  // memory port steering: clearing sweep or one lane access
  always_comb begin
    instr_en  = 1'b0;
    data_en   = 1'b0;
    video_en  = 1'b0;
    stack_en  = 1'b0;
    instr_we  = 1'b0;
    data_we   = 1'b0;
    video_we  = 1'b0;
    stack_we  = 1'b0;
    mem_wdata = lane_wbyte;
    if (cmd.clear) begin
      mem_wdata  = 8'h00;
      instr_en   = ({1'b0, clr_cnt} < (OW + 1)'(INSTR_BYTES));
      data_en    = ({1'b0, clr_cnt} < (OW + 1)'(DATA_BYTES));
      video_en   = ({1'b0, clr_cnt} < (OW + 1)'(VIDEO_BYTES));
      stack_en   = ({1'b0, clr_cnt} < (OW + 1)'(STACK_BYTES));
      instr_we   = instr_en;
      data_we    = data_en;
      video_we   = video_en;
      stack_we   = stack_en;
      instr_addr = clr_cnt[IAW-1:0];
      data_addr  = clr_cnt[DAW-1:0];
      video_addr = clr_cnt[VAW-1:0];
      stack_addr = clr_cnt[SAW-1:0];
    end else begin
      instr_en   = cmd.access && (region == REGION_INSTR);
      data_en    = cmd.access && (region == REGION_DATA);
      video_en   = cmd.access && (region == REGION_VIDEO);
      stack_en   = cmd.access && (region == REGION_STACK);
      instr_we   = instr_en && is_write;
      data_we    = data_en && is_write;
      video_we   = video_en && is_write;
      stack_we   = stack_en && is_write;
      instr_addr = offset[IAW-1:0];
      data_addr  = offset[DAW-1:0];
      video_addr = offset[VAW-1:0];
      stack_addr = offset[SAW-1:0];
    end
  end

  always_comb begin
    case (region)
      REGION_INSTR: rbyte = instr_rdata;
      REGION_DATA:  rbyte = data_rdata;
      REGION_VIDEO: rbyte = video_rdata;
      REGION_STACK: rbyte = stack_rdata;
      default:      rbyte = 8'h00;
    endcase
  end

  smba_ram #(.DEPTH(INSTR_BYTES)) u_instr (
    .clk(clk), .en(instr_en), .we(instr_we), .addr(instr_addr),
    .wdata(mem_wdata), .rdata(instr_rdata)
  );

  smba_ram #(.DEPTH(DATA_BYTES)) u_data (
    .clk(clk), .en(data_en), .we(data_we), .addr(data_addr),
    .wdata(mem_wdata), .rdata(data_rdata)
  );

  smba_ram #(.DEPTH(VIDEO_BYTES)) u_video (
    .clk(clk), .en(video_en), .we(video_we), .addr(video_addr),
    .wdata(mem_wdata), .rdata(video_rdata)
  );

  smba_ram #(.DEPTH(STACK_BYTES)) u_stack (
    .clk(clk), .en(stack_en), .we(stack_we), .addr(stack_addr),
    .wdata(mem_wdata), .rdata(stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      read_data <= result;
    end
  end

  `SMBA_ASSERT_IMP(a_write_mode, (instr_we || data_we || video_we || stack_we) && !cmd.clear, is_write, "store written outside a write access")
  `SMBA_ASSERT_IMP(a_lane_range, cmd.access, lane <= last_lane_of(mode_r), "lane beyond access size")

endmodule

// ===== design/soc_memory_map_byte_access_top.sv =====
// ----------------------------------------------------------------------------
// soc_memory_map_byte_access_top
// Little-endian byte-decoded memory map: instruction, data, video, stack.
//
//   channel  handshake            payload
//   -------  -------------------  ---------------------------------------------
//   in       in_valid / in_ready  mode, address, write_data, keypad_state,
//                                 timer_value
//   out      out_valid/out_ready  read_data
//   cfg      cfg_write            cfg_index, cfg_data
//
// After reset a clearing sweep zeroes all four stores, one address of each
// per cycle, over every address below max(INSTR/DATA/VIDEO/STACK_BYTES);
// no item is taken meanwhile, config writes are. One byte lane at a time
// goes through a single decoder and the single-port stores: a read lane
// passes decode, access and merge, a write lane decode and access, a port
// read goes from decode to finish. A finished result waits in the output
// register; the next item is taken meanwhile and held in finish until it frees.
// ----------------------------------------------------------------------------
module soc_memory_map_byte_access_top import smba_pkg::*; #(
  parameter int INSTR_BYTES = INSTR_BYTES_DEF,
  parameter int DATA_BYTES  = DATA_BYTES_DEF,
  parameter int STACK_BYTES = STACK_BYTES_DEF,
  parameter int VIDEO_BYTES = VIDEO_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           mode,
  input  logic [31:0]          address,
  input  logic [31:0]          write_data,
  input  logic [15:0]          keypad_state,
  input  logic [31:0]          timer_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          read_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cmd_t    cmd;
  status_t status;

  smba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  smba_dpath #(
    .INSTR_BYTES (INSTR_BYTES),
    .DATA_BYTES  (DATA_BYTES),
    .STACK_BYTES (STACK_BYTES),
    .VIDEO_BYTES (VIDEO_BYTES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .address      (address),
    .write_data   (write_data),
    .keypad_state (keypad_state),
    .timer_value  (timer_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data)
  );

endmodule

// ===== test/tb_soc_memory_map_byte_access_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_soc_memory_map_byte_access_top
// Self-checking bench for the byte-decoded memory map.
//
// A short directed table covers the port reads, region ends and straddles,
// address wrap and the unused modes. Random accesses follow across several
// map settings: defaults, back-to-back regions, wrapping regions, all-zero
// and all-ones registers, random bases and overlapping regions. Results are
// checked with a byte-level model of the four stores, pinned rows with the
// table, under random sender gaps, receiver stalls and one long output hold.
// ----------------------------------------------------------------------------
module tb_soc_memory_map_byte_access_top;
  import smba_pkg::*;

  localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  localparam int MAP_SETTINGS     = 8;
  localparam int RANDOM_PER_SET   = 203;
  localparam int PRESSURE_SETTING = 4;
  localparam int HOLD_CYCLES      = 400;
  localparam int SETTLE_CYCLES    = 16;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [15:0] keypad;
    logic [31:0] timer;
    logic        pinned;
    logic [31:0] want;
  } access_row_t;

  localparam int DIRECTED_ROWS = 26;
  localparam access_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{MODE_RD_WORD,   32'h1001_0000, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{MODE_RD_WORD,   32'hFFFF_0000, 32'h0000_0000, 16'hFFFF, 32'h0000_0000, 1'b1, 32'h0000_FFFF},
    '{MODE_RD_WORD,   32'hFFFF_0004, 32'h0000_0000, 16'h1234, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{MODE_RD_WORD,   32'hFFFF_0000, 32'h0000_0000, 16'h0000, 32'hAAAA_5555, 1'b1, 32'h0000_0000},
    '{MODE_WR_WORD,   32'h1001_0000, 32'hDEAD_BEEF, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{MODE_RD_WORD,   32'h1001_0000, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1, 32'hDEAD_BEEF},
    '{MODE_RD_BYTE,   32'h1001_0003, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_00DE},
    '{MODE_RD_HALF,   32'h1001_0001, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_ADBE},
    '{MODE_WR_HALF,   32'h0040_0000, 32'hFFFF_1234, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{MODE_RD_WORD,   32'h0040_0000, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_1234},
    '{MODE_WR_BYTE,   32'h1002_12BF, 32'h0000_00A5, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{MODE_RD_HALF,   32'h1002_12BF, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_00A5},
    '{MODE_WR_WORD,   32'h7FFF_FFFE, 32'h1122_3344, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{MODE_RD_WORD,   32'h7FFF_FFFE, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_3344},
    '{MODE_WR_WORD,   32'h7FFF_FBFE, 32'hCAFE_F00D, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{MODE_RD_WORD,   32'h7FFF_FC00, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_CAFE},
    '{MODE_UNUSED_LO, 32'h1001_0000, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{MODE_UNUSED_HI, 32'h1001_0000, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{MODE_RD_HALF,   32'hFFFF_0000, 32'h0000_0000, 16'hFFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{MODE_WR_WORD,   32'hFFFF_0004, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{MODE_WR_WORD,   32'h0040_0FFE, 32'h5566_7788, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{MODE_RD_WORD,   32'h0040_0FFE, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{MODE_RD_WORD,   32'hFFFF_FFFE, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{MODE_RD_BYTE,   32'h0000_0000, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{MODE_RD_WORD,   32'h1001_0FFD, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{MODE_RD_WORD,   32'h1001_0000, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b0, 32'h0000_0000}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           mode = MODE_RD_BYTE;
  logic [31:0]          address = '0;
  logic [31:0]          write_data = '0;
  logic [15:0]          keypad_state = '0;
  logic [31:0]          timer_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [31:0]          read_data;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_INSTR_BASE;
  logic [31:0]          cfg_data = '0;

  // expectation pinned to the item on offer, for the directed rows
  logic        pin_en = 1'b0;
  logic [31:0] pin_val = '0;

  logic [31:0] map_regs [6];
  logic [7:0]  instr_mem [INSTR_BYTES_DEF];
  logic [7:0]  data_mem  [DATA_BYTES_DEF];
  logic [7:0]  video_mem [VIDEO_BYTES_DEF];
  logic [7:0]  stack_mem [STACK_BYTES_DEF];
  logic [31:0] pending_read_data [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int mismatches     = 0;

  soc_memory_map_byte_access_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .address      (address),
    .write_data   (write_data),
    .keypad_state (keypad_state),
    .timer_value  (timer_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: %s: got %08h, expected %08h", $time, what, got, want);
  endtask

  // Read one byte of the map and optionally replace it; unmapped bytes
  // read as zero and swallow writes.
  function automatic logic [7:0] touch_byte(input logic [31:0] a, input bit wr,
                                            input logic [7:0] v);
    region_t     r;
    logic [31:0] off;
    logic [31:0] sbase;
    logic [7:0]  got;
    sbase = map_regs[REG_STACK_TOP] - 32'(STACK_BYTES_DEF) + 32'd1;
    r = REGION_NONE;
    off = '0;
    got = 8'h00;
    if (a - map_regs[REG_INSTR_BASE] < 32'(INSTR_BYTES_DEF)) begin
      r = REGION_INSTR;
      off = a - map_regs[REG_INSTR_BASE];
    end else if (a - map_regs[REG_DATA_BASE] < 32'(DATA_BYTES_DEF)) begin
      r = REGION_DATA;
      off = a - map_regs[REG_DATA_BASE];
    end else if (a - map_regs[REG_VIDEO_BASE] < 32'(VIDEO_BYTES_DEF)) begin
      r = REGION_VIDEO;
      off = a - map_regs[REG_VIDEO_BASE];
    end else if (a - sbase < 32'(STACK_BYTES_DEF)) begin
      r = REGION_STACK;
      off = a - sbase;
    end
    case (r)
      REGION_INSTR: begin
        got = instr_mem[off];
        if (wr) instr_mem[off] = v;
      end
      REGION_DATA: begin
        got = data_mem[off];
        if (wr) data_mem[off] = v;
      end
      REGION_VIDEO: begin
        got = video_mem[off];
        if (wr) video_mem[off] = v;
      end
      REGION_STACK: begin
        got = stack_mem[off];
        if (wr) stack_mem[off] = v;
      end
      default: got = 8'h00;
    endcase
    return got;
  endfunction

  function automatic logic [31:0] map_access(input logic [2:0] op, input logic [31:0] a,
                                             input logic [31:0] wd, input logic [15:0] kp,
                                             input logic [31:0] tv);
    logic [31:0] result;
    logic [7:0]  b;
    int          lanes;
    bit          is_read;
    result = '0;
    case (op)
      MODE_RD_BYTE, MODE_WR_BYTE: lanes = 1;
      MODE_RD_HALF, MODE_WR_HALF: lanes = 2;
      MODE_RD_WORD, MODE_WR_WORD: lanes = 4;
      default:                    lanes = 0;
    endcase
    is_read = (op == MODE_RD_BYTE) || (op == MODE_RD_HALF) || (op == MODE_RD_WORD);
    if (op == MODE_RD_WORD && a == map_regs[REG_KEYPAD_ADDR]) begin
      result = {16'h0000, kp};
    end else if (op == MODE_RD_WORD && a == map_regs[REG_TIMER_ADDR]) begin
      result = tv;
    end else begin
      for (int k = 0; k < lanes; k++) begin
        b = touch_byte(a + 32'(k), !is_read, wd[8*k +: 8]);
        if (is_read) result[8*k +: 8] = b;
      end
    end
    return result;
  endfunction

  // Predict at acceptance, check at delivery.
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      for (int i = 0; i < INSTR_BYTES_DEF; i++) instr_mem[i] = 8'h00;
      for (int i = 0; i < DATA_BYTES_DEF; i++) data_mem[i] = 8'h00;
      for (int i = 0; i < VIDEO_BYTES_DEF; i++) video_mem[i] = 8'h00;
      for (int i = 0; i < STACK_BYTES_DEF; i++) stack_mem[i] = 8'h00;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_read_data.size() == 0) begin
          report_mismatch("result with nothing outstanding", read_data, 32'h0);
        end else begin
          want = pending_read_data.pop_front();
          if (read_data !== want) report_mismatch("read_data", read_data, want);
          results_checked++;
        end
      end
      if (in_valid && in_ready) begin
        want = map_access(mode, address, write_data, keypad_state, timer_value);
        if (pin_en) want = pin_val;
        pending_read_data.push_back(want);
        items_accepted++;
      end
    end
  end

  // Output side: random stalls, plus a long hold when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    map_regs[idx] <= val;
    @(posedge clk);
  endtask

  task automatic program_map(input int setting);
    logic [31:0] v [6];
    logic [31:0] b;
    b = $urandom();
    case (setting)
      1: begin
        // regions back to back, ports inside the first two
        b = 32'h0001_0000;
        v[REG_INSTR_BASE]  = b;
        v[REG_DATA_BASE]   = b + 32'(INSTR_BYTES_DEF);
        v[REG_VIDEO_BASE]  = v[REG_DATA_BASE] + 32'(DATA_BYTES_DEF);
        v[REG_STACK_TOP]   = v[REG_VIDEO_BASE] + 32'(VIDEO_BYTES_DEF + STACK_BYTES_DEF - 1);
        v[REG_KEYPAD_ADDR] = b;
        v[REG_TIMER_ADDR]  = v[REG_DATA_BASE] + 32'd8;
      end
      2: begin
        // regions wrapping across the top of the address space
        v[REG_INSTR_BASE]  = 32'hFFFF_F800;
        v[REG_DATA_BASE]   = 32'h0000_0000;
        v[REG_VIDEO_BASE]  = 32'hFFFF_FFFF;
        v[REG_STACK_TOP]   = 32'h0000_0100;
        v[REG_KEYPAD_ADDR] = 32'hFFFF_FFFF;
        v[REG_TIMER_ADDR]  = 32'h0000_0000;
      end
      3: foreach (v[i]) v[i] = 32'h0000_0000;
      4: foreach (v[i]) v[i] = 32'hFFFF_FFFF;
      5: foreach (v[i]) v[i] = $urandom();
      6: begin
        // overlapping regions and a shared port address
        v[REG_INSTR_BASE]  = b;
        v[REG_DATA_BASE]   = b;
        v[REG_VIDEO_BASE]  = b - 32'd2048;
        v[REG_STACK_TOP]   = b + 32'd4607;
        v[REG_KEYPAD_ADDR] = b + 32'd16;
        v[REG_TIMER_ADDR]  = b + 32'd16;
      end
      default: begin
        v[REG_INSTR_BASE]  = RST_INSTR_BASE;
        v[REG_DATA_BASE]   = RST_DATA_BASE;
        v[REG_VIDEO_BASE]  = RST_VIDEO_BASE;
        v[REG_STACK_TOP]   = RST_STACK_TOP;
        v[REG_KEYPAD_ADDR] = RST_KEYPAD_ADDR;
        v[REG_TIMER_ADDR]  = RST_TIMER_ADDR;
      end
    endcase
    for (int i = REG_INSTR_BASE; i <= REG_TIMER_ADDR; i++)
      write_reg(CFG_IDX_W'(i), v[i]);
    cfg_write <= 1'b0;
  endtask

  // Offer one item and return once it has been taken.
  task automatic send_access(input logic [2:0] op, input logic [31:0] a,
                             input logic [31:0] wd, input logic [15:0] kp,
                             input logic [31:0] tv, input logic pinned,
                             input logic [31:0] want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= op;
    address <= a;
    write_data <= wd;
    keypad_state <= kp;
    timer_value <= tv;
    pin_en <= pinned;
    pin_val <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_access();
    logic [2:0]  op;
    logic [31:0] a;
    logic [31:0] base;
    int unsigned span;
    int unsigned sel;
    int unsigned r;
    sel = $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    span = STACK_BYTES_DEF;
    if (r < 4) op = MODE_UNUSED_LO + 3'($urandom_range(0, 1));
    else if (r < 52) op = MODE_RD_BYTE + 3'($urandom_range(0, 2));
    else op = MODE_WR_BYTE + 3'($urandom_range(0, 2));
    if (sel < 74) begin
      case ($urandom_range(0, 3))
        0: begin base = map_regs[REG_INSTR_BASE]; span = INSTR_BYTES_DEF; end
        1: begin base = map_regs[REG_DATA_BASE];  span = DATA_BYTES_DEF;  end
        2: begin base = map_regs[REG_VIDEO_BASE]; span = VIDEO_BYTES_DEF; end
        default: base = map_regs[REG_STACK_TOP] - 32'(STACK_BYTES_DEF) + 32'd1;
      endcase
      // favour a small window so reads find earlier writes
      case ($urandom_range(0, 4))
        0, 1: a = base + $urandom_range(0, 47);
        2: a = base + $urandom_range(0, span - 1);
        3: a = base + span - 4 + $urandom_range(0, 6);
        default: a = base - 3 + $urandom_range(0, 3);
      endcase
    end else if (sel < 86) begin
      a = $urandom_range(0, 1) ? map_regs[REG_KEYPAD_ADDR] : map_regs[REG_TIMER_ADDR];
      if ($urandom_range(0, 3) == 0) a = a + $urandom_range(1, 3);
      if ($urandom_range(0, 9) < 7) op = MODE_RD_WORD;
    end else begin
      a = $urandom();
    end
    send_access(op, a, $urandom(), 16'($urandom_range(0, 65535)), $urandom(), 1'b0, 32'h0);
  endtask

  task automatic drain_results();
    while (pending_read_data.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int s = 0; s < MAP_SETTINGS; s++) begin
      if (s != 0) drain_results();
      case (s % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 51; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 51; end
        default: begin send_idle_pct <= 38; recv_stall_pct <= 38; end
      endcase
      program_map(s);
      if (s == 0) begin
        foreach (DIRECTED[i])
          send_access(DIRECTED[i].op, DIRECTED[i].addr, DIRECTED[i].wdata,
                      DIRECTED[i].keypad, DIRECTED[i].timer,
                      DIRECTED[i].pinned, DIRECTED[i].want);
      end
      // hold the output long enough to back the block up
      if (s == PRESSURE_SETTING) hold_requests <= hold_requests + 1;
      repeat (RANDOM_PER_SET) send_random_access();
      in_valid <= 1'b0;
    end
    drain_results();
    $display("Ran %0d accesses (%0d directed) over %0d map settings with gaps and stalls.",
             items_accepted, DIRECTED_ROWS, MAP_SETTINGS);
    $display("Checked %0d results, %0d mismatches, %0d long output hold(s).",
             results_checked, mismatches, hold_served);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
